[sv/ilist_pkg.sv]
package ilist_pkg;

  // List geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int PTR_W    = IDX_W + 1;
  localparam int VALUE_W  = 32;

  // Pointer value meaning "no node"
  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(CAPACITY);

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOB  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // One node of the list as held in the node memory
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [PTR_W-1:0]          next;
    logic [PTR_W-1:0]          prev;
  } node_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    node_t            data;
  } node_wr_t;

  // Requests to the free node allocator
  typedef struct packed {
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] node;
  } free_req_t;

endpackage

[sv/ilist_ram.sv]
module ilist_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/ilist_free.sv]
module ilist_free (
  input  logic                        clk,
  input  logic                        rst,
  input  ilist_pkg::free_req_t        req,
  output logic [ilist_pkg::IDX_W-1:0] alloc_idx
);
  import ilist_pkg::*;

  // rc: nodes on the recycle stack; fresh: nodes handed out since reset
  // from the never-used pool. Free nodes = rc + CAPACITY - fresh.
  logic [PTR_W-1:0] rc;
  logic [PTR_W-1:0] fresh;
  logic [PTR_W-1:0] rc_dec;
  logic [IDX_W-1:0] stack_top;

  assign rc_dec = rc - PTR_W'(1);

  // Read port always tracks the top of the stack
  ilist_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (IDX_W)
  ) u_stack (
    .clk     (clk),
    .wr_en   (req.push),
    .wr_addr (rc[IDX_W-1:0]),
    .wr_data (req.node),
    .rd_addr (rc_dec[IDX_W-1:0]),
    .rd_data (stack_top)
  );

  // Recycled nodes first, then never-used ones
  assign alloc_idx = (rc != '0) ? stack_top : fresh[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rc    <= '0;
      fresh <= '0;
    end else if (req.push) begin
      rc <= rc + PTR_W'(1);
    end else if (req.pop) begin
      if (rc != '0) begin
        rc <= rc_dec;
      end else begin
        fresh <= fresh + PTR_W'(1);
      end
    end
  end

endmodule

[sv/ilist_ctrl.sv]
module ilist_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                command,
  input  logic [ilist_pkg::PTR_W-1:0]         position,
  input  logic signed [ilist_pkg::VALUE_W-1:0] item_value,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [1:0]                          status,
  output logic signed [ilist_pkg::VALUE_W-1:0] removed_value,
  output logic [ilist_pkg::PTR_W-1:0]         list_length,
  output logic [ilist_pkg::IDX_W-1:0]         node_rd_addr,
  input  ilist_pkg::node_t                    node_rd_data,
  output ilist_pkg::node_wr_t                 node_wr,
  output ilist_pkg::free_req_t                free_req,
  input  logic [ilist_pkg::IDX_W-1:0]         alloc_idx
);
  import ilist_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_FIX_PRED,
    S_WR_PRED,
    S_FIX_SUCC,
    S_WR_SUCC,
    S_RESULT
  } state_t;

  state_t               state;
  logic                 is_del;
  logic [PTR_W-1:0]     pos;
  logic signed [VALUE_W-1:0] val;
  logic [PTR_W-1:0]     count;
  logic [PTR_W-1:0]     count_next;
  logic [PTR_W-1:0]     head;
  logic [PTR_W-1:0]     tail;
  logic [PTR_W-1:0]     cur;
  logic [PTR_W-1:0]     step;
  logic [PTR_W-1:0]     pred;
  logic [PTR_W-1:0]     succ;
  logic [PTR_W-1:0]     pred_link;
  logic [PTR_W-1:0]     succ_link;
  logic signed [VALUE_W-1:0] rm_val;
  status_t              res_st;
  logic                 res_load;

  assign req_stall = (state != S_IDLE);
  assign res_load  = !res_valid || !res_stall;

  // Length after the request
  always_comb begin
    count_next = count;
    if (res_st == ST_OK) begin
      count_next = is_del ? count - PTR_W'(1) : count + PTR_W'(1);
    end
  end

  // Node memory read address: head while idle, next link while walking,
  // neighbour node during link repair
  always_comb begin
    case (state)
      S_WALK:     node_rd_addr = node_rd_data.next[IDX_W-1:0];
      S_FIX_PRED: node_rd_addr = pred[IDX_W-1:0];
      S_FIX_SUCC: node_rd_addr = succ[IDX_W-1:0];
      default:    node_rd_addr = head[IDX_W-1:0];
    endcase
  end

  // Node memory writes: new node on insert, then read-modify-write of neighbours
  always_comb begin
    node_wr.en   = 1'b0;
    node_wr.addr = alloc_idx;
    node_wr.data = node_rd_data;
    case (state)
      S_ALLOC: begin
        node_wr.en         = 1'b1;
        node_wr.addr       = alloc_idx;
        node_wr.data.value = val;
        node_wr.data.next  = succ;
        node_wr.data.prev  = pred;
      end
      S_WR_PRED: begin
        node_wr.en        = 1'b1;
        node_wr.addr      = pred[IDX_W-1:0];
        node_wr.data.next = pred_link;
      end
      S_WR_SUCC: begin
        node_wr.en        = 1'b1;
        node_wr.addr      = succ[IDX_W-1:0];
        node_wr.data.prev = succ_link;
      end
      default: ;
    endcase
  end

  // Allocator: pop on insert, push the removed node on delete
  assign free_req.pop  = (state == S_ALLOC);
  assign free_req.push = (state == S_RESULT) && res_load && is_del && (res_st == ST_OK);
  assign free_req.node = cur[IDX_W-1:0];

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= NIL_PTR;
      tail      <= NIL_PTR;
      res_valid <= 1'b0;
    end else begin
      // result valid: set when a result is loaded, cleared once taken
      if (state == S_RESULT && res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            is_del <= (command == CMD_DELETE);
            pos    <= position;
            val    <= item_value;
            cur    <= head;
            step   <= '0;
            if ((command == CMD_DELETE && position >= count) ||
                (command == CMD_INSERT && position > count)) begin
              res_st <= ST_OOB;
              rm_val <= '1;
              state  <= S_RESULT;
            end else if (command == CMD_INSERT && count >= PTR_W'(CAPACITY)) begin
              res_st <= ST_FULL;
              rm_val <= '1;
              state  <= S_RESULT;
            end else begin
              res_st <= ST_OK;
              rm_val <= '0;
              if (command == CMD_INSERT && position == count) begin
                // append at the tail
                pred  <= tail;
                succ  <= NIL_PTR;
                state <= S_ALLOC;
              end else begin
                state <= S_WALK;
              end
            end
          end
        end
        S_WALK: begin
          // read data holds the node at list place step
          if (step == pos) begin
            if (is_del) begin
              pred      <= node_rd_data.prev;
              succ      <= node_rd_data.next;
              pred_link <= node_rd_data.next;
              succ_link <= node_rd_data.prev;
              rm_val    <= node_rd_data.value;
              state     <= S_FIX_PRED;
            end else begin
              pred  <= node_rd_data.prev;
              succ  <= cur;
              state <= S_ALLOC;
            end
          end else begin
            cur  <= node_rd_data.next;
            step <= step + PTR_W'(1);
          end
        end
        S_ALLOC: begin
          pred_link <= {1'b0, alloc_idx};
          succ_link <= {1'b0, alloc_idx};
          state     <= S_FIX_PRED;
        end
        S_FIX_PRED: begin
          if (pred == NIL_PTR) begin
            head  <= pred_link;
            state <= S_FIX_SUCC;
          end else begin
            state <= S_WR_PRED;
          end
        end
        S_WR_PRED: begin
          state <= S_FIX_SUCC;
        end
        S_FIX_SUCC: begin
          if (succ == NIL_PTR) begin
            tail  <= succ_link;
            state <= S_RESULT;
          end else begin
            state <= S_WR_SUCC;
          end
        end
        S_WR_SUCC: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (res_load) begin
            status        <= res_st;
            removed_value <= rm_val;
            list_length   <= count_next;
            count         <= count_next;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/indexed_list_insert_delete.sv]
// Positional insert/delete on a bounded doubly linked list of signed
// 32-bit values, up to 64 elements.
// Request channel (req_valid/req_stall): command (0 insert item_value
// before position, 1 delete the element at position), position, item_value.
// Result channel (res_valid/res_stall): exactly one result per request,
// giving status (ok, out of bound, full), removed_value (deleted value,
// -1 on error, 0 on insert) and list_length after the request.
// One request is in flight at a time. A request that fails its range or
// full check goes straight to the result state. An append skips the
// walk; any other insert and a good delete walk the node memory from the
// head one node per cycle, then the neighbours are patched by
// read-modify-write. The block returns to idle once the result is loaded
// and takes the next request there.
// The result sits in an output register, so the next request is taken
// while an earlier result still waits on res_stall; a new result is held
// back until that register is free.
// Reset (rst, synchronous) empties the list and frees all nodes at once;
// the node and free memories need no clearing pass.
module indexed_list_insert_delete (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                command,
  input  logic [ilist_pkg::PTR_W-1:0]         position,
  input  logic signed [ilist_pkg::VALUE_W-1:0] item_value,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [1:0]                          status,
  output logic signed [ilist_pkg::VALUE_W-1:0] removed_value,
  output logic [ilist_pkg::PTR_W-1:0]         list_length
);
  import ilist_pkg::*;

  logic [IDX_W-1:0] node_rd_addr;
  node_t            node_rd_data;
  node_wr_t         node_wr;
  free_req_t        free_req;
  logic [IDX_W-1:0] alloc_idx;

  // Node memory: value and both links of each node
  ilist_ram #(
    .DEPTH (CAPACITY),
    .WIDTH ($bits(node_t))
  ) u_nodes (
    .clk     (clk),
    .wr_en   (node_wr.en),
    .wr_addr (node_wr.addr),
    .wr_data (node_wr.data),
    .rd_addr (node_rd_addr),
    .rd_data (node_rd_data)
  );

  ilist_free u_free (
    .clk       (clk),
    .rst       (rst),
    .req       (free_req),
    .alloc_idx (alloc_idx)
  );

  ilist_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .command       (command),
    .position      (position),
    .item_value    (item_value),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .status        (status),
    .removed_value (removed_value),
    .list_length   (list_length),
    .node_rd_addr  (node_rd_addr),
    .node_rd_data  (node_rd_data),
    .node_wr       (node_wr),
    .free_req      (free_req),
    .alloc_idx     (alloc_idx)
  );

endmodule

[sv/ilist_chk.sv]
module ilist_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_stall,
  input logic                                res_valid,
  input logic                                res_stall,
  input logic [1:0]                          status,
  input logic signed [ilist_pkg::VALUE_W-1:0] removed_value,
  input logic [ilist_pkg::PTR_W-1:0]         list_length
);
  import ilist_pkg::*;

  // Length never exceeds capacity
  a_len_max: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (list_length <= PTR_W'(CAPACITY)))
    else $error("list length above capacity");

  // Full is only reported on a full list
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == ST_FULL) |-> (list_length == PTR_W'(CAPACITY)))
    else $error("full status with room left");

  // Failed requests report -1
  a_err_val: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (status == ST_OOB || status == ST_FULL)) |-> (removed_value == '1))
    else $error("error result without -1");

  // No status code beyond full
  a_status: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (status == ST_OK || status == ST_OOB || status == ST_FULL))
    else $error("unknown status code");

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(status)
      && $stable(removed_value) && $stable(list_length)))
    else $error("stalled result changed");

endmodule

bind indexed_list_insert_delete ilist_chk u_chk (.*);

[sim/tb.sv]
module tb;
  import ilist_pkg::*;

  localparam int ITEMS          = 1300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 100;

  localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VNEG = -32'sd1;

  // One result as the block should give it
  typedef struct packed {
    status_t                   st;
    logic signed [VALUE_W-1:0] rem;
    logic [PTR_W-1:0]          len;
  } result_t;

  // Directed row; known marks an expected result typed in by hand
  typedef struct packed {
    logic                      cmd;
    logic [PTR_W-1:0]          pos;
    logic signed [VALUE_W-1:0] val;
    logic                      known;
    result_t                   res;
  } dir_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  localparam result_t NO_RES = '{ST_OK, 32'sd0, 7'd0};

  localparam int DIR_ROWS = 19;
  localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
    '{CMD_DELETE, 7'd0,   32'sd0,        1'b1, '{ST_OOB, VNEG,   7'd0}},  // delete on empty
    '{CMD_INSERT, 7'd1,   32'sd5,        1'b1, '{ST_OOB, VNEG,   7'd0}},  // insert past length
    '{CMD_INSERT, 7'd127, VMAX,          1'b1, '{ST_OOB, VNEG,   7'd0}},
    '{CMD_DELETE, 7'd64,  VMIN,          1'b1, '{ST_OOB, VNEG,   7'd0}},
    '{CMD_INSERT, 7'd0,   VMAX,          1'b1, '{ST_OK,  32'sd0, 7'd1}},  // first element
    '{CMD_INSERT, 7'd1,   VMIN,          1'b1, '{ST_OK,  32'sd0, 7'd2}},  // at tail
    '{CMD_INSERT, 7'd0,   VNEG,          1'b1, '{ST_OK,  32'sd0, 7'd3}},  // at head
    '{CMD_INSERT, 7'd1,   32'sd0,        1'b1, '{ST_OK,  32'sd0, 7'd4}},  // in the middle
    '{CMD_INSERT, 7'd5,   32'sd7,        1'b1, '{ST_OOB, VNEG,   7'd4}},
    '{CMD_DELETE, 7'd4,   32'sd0,        1'b1, '{ST_OOB, VNEG,   7'd4}},  // delete at length
    '{CMD_DELETE, 7'd2,   32'sd0,        1'b1, '{ST_OK,  VMAX,   7'd3}},  // middle delete
    '{CMD_INSERT, 7'd3,   32'sh5555_5555, 1'b0, NO_RES},
    '{CMD_INSERT, 7'd2,   32'shaaaa_aaaa, 1'b0, NO_RES},
    '{CMD_DELETE, 7'd4,   VMAX,          1'b0, NO_RES},                   // tail delete
    '{CMD_DELETE, 7'd0,   VMIN,          1'b0, NO_RES},                   // head delete
    '{CMD_DELETE, 7'd1,   32'sd0,        1'b0, NO_RES},
    '{CMD_DELETE, 7'd0,   32'sd0,        1'b0, NO_RES},
    '{CMD_DELETE, 7'd0,   32'sd0,        1'b0, NO_RES},                   // last element
    '{CMD_DELETE, 7'd0,   32'sd0,        1'b1, '{ST_OOB, VNEG,   7'd0}}
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      req_valid = 1'b0;
  logic                      req_stall;
  logic                      command = CMD_INSERT;
  logic [PTR_W-1:0]          position = '0;
  logic signed [VALUE_W-1:0] item_value = '0;
  logic                      res_valid;
  logic                      res_stall = 1'b0;
  logic [1:0]                status;
  logic signed [VALUE_W-1:0] removed_value;
  logic [PTR_W-1:0]          list_length;

  // Contents of the list as the block should hold it, head first
  logic signed [VALUE_W-1:0] list_model [$];
  result_t                   pending_results [$];

  int          err_count   = 0;
  int          n_sent      = 0;
  int          burst_left  = 0;
  int          idle_cycles = 0;
  int          stall_timer = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  logic [3:0]  stall_phase = '0;

  indexed_list_insert_delete u_top (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .command       (command),
    .position      (position),
    .item_value    (item_value),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .status        (status),
    .removed_value (removed_value),
    .list_length   (list_length)
  );

  always #5 clk = ~clk;

  // Apply one request to the list model and return the result it yields
  function automatic result_t apply_to_list(logic cmd, logic [PTR_W-1:0] pos,
                                            logic signed [VALUE_W-1:0] val);
    result_t r;
    int      p;
    p     = int'(pos);
    r.st  = ST_OK;
    r.rem = '0;
    if (cmd == CMD_INSERT) begin
      if (p > list_model.size()) begin
        r.st  = ST_OOB;
        r.rem = VNEG;
      end else if (list_model.size() >= CAPACITY) begin
        r.st  = ST_FULL;
        r.rem = VNEG;
      end else if (p == list_model.size()) begin
        list_model.push_back(val);
      end else begin
        list_model.insert(p, val);
      end
    end else begin
      if (p >= list_model.size()) begin
        r.st  = ST_OOB;
        r.rem = VNEG;
      end else begin
        r.rem = list_model[p];
        list_model.delete(p);
      end
    end
    r.len = PTR_W'(list_model.size());
    return r;
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 11))
      0:       return VMAX;
      1:       return VMIN;
      2:       return 32'sd0;
      3:       return VNEG;
      default: return $urandom;
    endcase
  endfunction

  // Drive one request in bursts with gaps, return once it is taken
  task automatic send_req(logic cmd, logic [PTR_W-1:0] pos,
                          logic signed [VALUE_W-1:0] val, result_t res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pending_results.push_back(res);
    req_valid  <= 1'b1;
    command    <= cmd;
    position   <= pos;
    item_value <= val;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    n_sent++;
  endtask

  // Random request: mostly well-formed positions, some anywhere in the field
  task automatic rand_req(int insert_pct, int noise_pct);
    logic                      cmd;
    logic [PTR_W-1:0]          pos;
    logic signed [VALUE_W-1:0] val;
    int                        len;
    len = list_model.size();
    cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
    val = rand_value();
    if ($urandom_range(0, 99) < noise_pct)
      pos = PTR_W'($urandom_range(0, 127));
    else if (cmd == CMD_INSERT)
      pos = PTR_W'($urandom_range(0, len));
    else
      pos = (len == 0) ? '0 : PTR_W'($urandom_range(0, len - 1));
    send_req(cmd, pos, val, apply_to_list(cmd, pos, val));
  endtask

  // Hold off new requests until every result is back
  task automatic wait_all_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Main sequence
  initial begin
    result_t pr;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_TBL[i]) begin
      pr = apply_to_list(DIR_TBL[i].cmd, DIR_TBL[i].pos, DIR_TBL[i].val);
      send_req(DIR_TBL[i].cmd, DIR_TBL[i].pos, DIR_TBL[i].val,
               DIR_TBL[i].known ? DIR_TBL[i].res : pr);
    end
    wait_all_results();

    while (n_sent < ITEMS) begin
      // grow until full
      while (list_model.size() < CAPACITY && n_sent < ITEMS) rand_req(85, 5);
      // inserts against a full list
      repeat (4) rand_req(100, 20);
      wait_all_results();
      // mixed traffic
      repeat ($urandom_range(50, 150)) rand_req(50, 10);
      // shrink to empty, then deletes on the empty list
      while (list_model.size() > 0 && n_sent < ITEMS) rand_req(15, 5);
      repeat (3) rand_req(0, 30);
      wait_all_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      err_count++;
    end
    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d removed_value %0d list_length %0d",
               status, removed_value, list_length);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) begin
          $error("status: expected %0d, actual %0d", want.st, status);
          err_count++;
        end
        if (removed_value !== want.rem) begin
          $error("removed_value: expected %0d, actual %0d", want.rem, removed_value);
          err_count++;
        end
        if (list_length !== want.len) begin
          $error("list_length: expected %0d, actual %0d", want.len, list_length);
          err_count++;
        end
      end
    end
  end

  // Receiver stall, in a pattern that changes at random times
  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode  <= stall_mode_t'($urandom_range(0, 3));
      stall_timer <= $urandom_range(64, 400);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    stall_phase <= stall_phase + 1'b1;
    case (stall_mode)
      STALL_NONE:     res_stall <= 1'b0;
      STALL_LIGHT:    res_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    res_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: res_stall <= (stall_phase < 4'd5);
      default:        res_stall <= 1'b0;
    endcase
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
